/* sv/assert_macros.svh */
// Assertion macros used by the RTL of the echo distance qualifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ued_pkg.sv */
// ----------------------------------------------------------------------------
// ued_pkg
// Types and constants of the ultrasonic echo distance qualifier.
// ----------------------------------------------------------------------------
package ued_pkg;

    localparam int unsigned DIST_W  = 10;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned CFG_W   = 16;

    // Commands
    localparam logic CMD_SLOT_END = 1'b0;
    localparam logic CMD_ECHO     = 1'b1;

    // Sensor slots
    localparam logic [1:0] SENSOR_RIGHT  = 2'd0;
    localparam logic [1:0] SENSOR_LEFT   = 2'd1;
    localparam logic [1:0] SENSOR_FRONT  = 2'd2;
    localparam logic [1:0] SENSOR_UNUSED = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_ECHO_OFFSET    = 2'd0;
    localparam logic [1:0] CFG_SPREAD_LIMIT   = 2'd1;
    localparam logic [1:0] CFG_UNSTABLE_VALUE = 2'd2;
    localparam logic [1:0] CFG_FAR_LIMIT      = 2'd3;

    // Configuration reset values
    localparam logic [15:0] RST_ECHO_OFFSET    = 16'd4454;
    localparam logic [8:0]  RST_SPREAD_LIMIT   = 9'd4;
    localparam logic [8:0]  RST_UNSTABLE_VALUE = 9'd100;
    localparam logic [9:0]  RST_FAR_LIMIT      = 10'd500;

    // Conversion: floor(q * 343 / 10000) == (q * SCALE_MULT) >> SCALE_SHIFT
    // holds exactly for every 14-bit q.
    localparam int unsigned SCALE_SHIFT = 28;
    localparam int unsigned SCALE_W     = 24;
    localparam logic [SCALE_W-1:0] SCALE_MULT = 24'd9207337;
    localparam logic [DIST_W-1:0]  WRAP_CODE  = 10'd561;
    localparam logic [DIST_W-1:0]  WRAP_VALUE = 10'd2;

    // Queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic               command;
        logic [COUNT_W-1:0] echo_count;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        active_sensor;
        logic [DIST_W-1:0] echo_distance;
        logic [DIST_W-1:0] left_stable;
        logic [DIST_W-1:0] right_stable;
        logic [DIST_W-1:0] front_distance;
    } out_item_t;

    typedef struct packed {
        logic [15:0] echo_offset;
        logic [8:0]  spread_limit;
        logic [8:0]  unstable_value;
        logic [9:0]  far_limit;
    } cfg_t;

    // Classified event passed from front to back.
    typedef struct packed {
        logic              is_echo;
        logic [DIST_W-1:0] distance;
    } evt_t;

endpackage

/* sv/ued_front.sv */
// ----------------------------------------------------------------------------
// ued_front
// Accepts input items, converts echo counts into filtered distances and
// holds the classified event in a register for the queue.
// ----------------------------------------------------------------------------
module ued_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  ued_pkg::cfg_t      cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  ued_pkg::in_item_t  s_data,
    output logic               evt_valid,
    input  logic               evt_ready,
    output ued_pkg::evt_t      evt_data
);

    localparam int unsigned PROD_W = ued_pkg::COUNT_W - 2 + ued_pkg::SCALE_W;

    logic [ued_pkg::COUNT_W-1:0] diff;
    logic [ued_pkg::COUNT_W-3:0] quarter;
    logic [PROD_W-1:0]           prod;
    logic [ued_pkg::DIST_W-1:0]  raw;
    logic [ued_pkg::DIST_W-1:0]  dist_filt;
    logic                        valid_reg;
    ued_pkg::evt_t               evt_reg;
    ued_pkg::evt_t               evt_next;

    always_comb begin
        diff    = s_data.echo_count - cfg.echo_offset;
        quarter = diff[ued_pkg::COUNT_W-1:2];
        prod    = PROD_W'(quarter) * PROD_W'(ued_pkg::SCALE_MULT);
        raw     = prod[ued_pkg::SCALE_SHIFT +: ued_pkg::DIST_W];
        if (raw == ued_pkg::WRAP_CODE) begin
            dist_filt = ued_pkg::WRAP_VALUE;
        end else if (raw >= cfg.far_limit) begin
            dist_filt = {1'b0, cfg.unstable_value};
        end else begin
            dist_filt = raw;
        end
        evt_next.is_echo  = (s_data.command == ued_pkg::CMD_ECHO);
        evt_next.distance = evt_next.is_echo ? dist_filt : '0;
    end

    assign s_ready   = !valid_reg || evt_ready;
    assign evt_valid = valid_reg;
    assign evt_data  = evt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            evt_reg <= evt_next;
        end
    end

endmodule

/* sv/ued_queue.sv */
// ----------------------------------------------------------------------------
// ued_queue
// Short first-in first-out queue of classified events between front and back.
// ----------------------------------------------------------------------------
module ued_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  ued_pkg::evt_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output ued_pkg::evt_t pop_data
);

    localparam int unsigned PW = ued_pkg::QUEUE_PTR_W;
    localparam int unsigned CW = ued_pkg::QUEUE_CNT_W;

    ued_pkg::evt_t entry_reg [ued_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          push;
    logic          pop;

    assign push_ready = (count_reg != CW'(ued_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(ued_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(ued_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* sv/ued_back.sv */
// ----------------------------------------------------------------------------
// ued_back
// Applies classified events to the sensor slot, the history rings and the
// front latch, and registers the qualified result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ued_back #(
    parameter int unsigned HISTORY_DEPTH = 3
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ued_pkg::cfg_t      cfg,
    input  logic               evt_valid,
    output logic               evt_ready,
    input  ued_pkg::evt_t      evt_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ued_pkg::out_item_t m_data
);

    localparam int unsigned DW = ued_pkg::DIST_W;
    localparam int unsigned PW = $clog2(HISTORY_DEPTH);

    typedef logic [HISTORY_DEPTH-1:0][DW-1:0] ring_t;

    logic [1:0]          slot_reg;
    logic [1:0]          slot_next;
    ring_t               left_ring_reg;
    ring_t               left_ring_next;
    ring_t               right_ring_reg;
    ring_t               right_ring_next;
    logic [PW-1:0]       left_pos_reg;
    logic [PW-1:0]       left_pos_next;
    logic [PW-1:0]       right_pos_reg;
    logic [PW-1:0]       right_pos_next;
    logic [DW-1:0]       front_reg;
    logic [DW-1:0]       front_next;
    logic                out_valid_reg;
    ued_pkg::out_item_t  out_reg;
    ued_pkg::out_item_t  out_next;
    logic                pop;
    logic                put_left;
    logic                put_right;
    logic                slot_ok;
    logic                pos_ok;
    logic                slot_end_pop;
    logic                out_zero;
    logic                front_pop;
    logic                front_match;

    // Minimum of the ring when its spread is small enough, else the unstable value.
    function automatic logic [DW-1:0] qualify(input ring_t ring, input logic [8:0] spread,
                                              input logic [8:0] unstable);
        logic [DW-1:0] lo;
        logic [DW-1:0] hi;
        lo = ring[0];
        hi = ring[0];
        for (int i = 1; i < HISTORY_DEPTH; i++) begin
            if (ring[i] > hi) begin
                hi = ring[i];
            end
            if (ring[i] < lo) begin
                lo = ring[i];
            end
        end
        return ((hi - lo) <= {1'b0, spread}) ? lo : {1'b0, unstable};
    endfunction

    assign pop       = evt_valid && (!out_valid_reg || m_ready);
    assign evt_ready = !out_valid_reg || m_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    assign put_left  = pop && evt_data.is_echo && (slot_reg == ued_pkg::SENSOR_LEFT)
                       && (evt_data.distance != '0);
    assign put_right = pop && evt_data.is_echo && (slot_reg == ued_pkg::SENSOR_RIGHT)
                       && (evt_data.distance != '0);

    always_comb begin
        slot_next       = slot_reg;
        left_ring_next  = left_ring_reg;
        right_ring_next = right_ring_reg;
        left_pos_next   = left_pos_reg;
        right_pos_next  = right_pos_reg;
        front_next      = front_reg;

        if (pop && !evt_data.is_echo) begin
            slot_next = (slot_reg >= ued_pkg::SENSOR_FRONT) ? ued_pkg::SENSOR_RIGHT
                                                             : slot_reg + 1'b1;
        end
        if (put_left) begin
            left_ring_next[left_pos_reg] = evt_data.distance;
            left_pos_next = (left_pos_reg == PW'(HISTORY_DEPTH - 1)) ? '0 : left_pos_reg + 1'b1;
        end
        if (put_right) begin
            right_ring_next[right_pos_reg] = evt_data.distance;
            right_pos_next = (right_pos_reg == PW'(HISTORY_DEPTH - 1)) ? '0
                                                                      : right_pos_reg + 1'b1;
        end
        if (pop && evt_data.is_echo && (slot_reg == ued_pkg::SENSOR_FRONT)) begin
            front_next = evt_data.distance;
        end

        out_next.active_sensor  = slot_next;
        out_next.echo_distance  = evt_data.is_echo ? evt_data.distance : '0;
        out_next.left_stable    = qualify(left_ring_next, cfg.spread_limit, cfg.unstable_value);
        out_next.right_stable   = qualify(right_ring_next, cfg.spread_limit, cfg.unstable_value);
        out_next.front_distance = front_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg       <= ued_pkg::SENSOR_RIGHT;
            left_ring_reg  <= '0;
            right_ring_reg <= '0;
            left_pos_reg   <= '0;
            right_pos_reg  <= '0;
            front_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            slot_reg       <= slot_next;
            left_ring_reg  <= left_ring_next;
            right_ring_reg <= right_ring_next;
            left_pos_reg   <= left_pos_next;
            right_pos_reg  <= right_pos_next;
            front_reg      <= front_next;
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= out_next;
        end
    end

    assign slot_ok      = (slot_reg != ued_pkg::SENSOR_UNUSED);
    assign pos_ok       = (left_pos_reg <= PW'(HISTORY_DEPTH - 1))
                          && (right_pos_reg <= PW'(HISTORY_DEPTH - 1));
    assign slot_end_pop = pop && !evt_data.is_echo;
    assign out_zero     = m_valid && (m_data.echo_distance == '0);
    assign front_pop    = pop && evt_data.is_echo && (slot_reg == ued_pkg::SENSOR_FRONT);
    assign front_match  = (m_data.front_distance == m_data.echo_distance);

    `ASSERT_ALWAYS(a_slot_in_range, aclk, aresetn, slot_ok, "unused sensor slot reached")
    `ASSERT_ALWAYS(a_pos_in_range, aclk, aresetn, pos_ok, "ring write position out of range")
    `ASSERT_NEXT(a_slot_end_zero, aclk, aresetn, slot_end_pop, out_zero, "distance on a slot end")
    `ASSERT_NEXT(a_front_latch, aclk, aresetn, front_pop, front_match, "front echo not latched")

endmodule

/* sv/ultrasonic_echo_distance_qualifier_top.sv */
// ----------------------------------------------------------------------------
// ultrasonic_echo_distance_qualifier_top
// Ultrasonic echo distance qualifier for right, left and front sensors.
// ----------------------------------------------------------------------------
// The block takes one command per cycle while s_ready is high and gives one
// result per command, in order. Each result passes through the front register,
// where the single 14 by 24 bit constant multiply of the count conversion sits,
// then the two-entry event queue and then the output register, loaded by the
// back part as it updates the rings and works out their minimum and spread.
// Throughput is one item per cycle when the output side does not stall, set by
// the conversion multiply and the ring update. Configuration is written through
// cfg_we, cfg_index and cfg_data; the user must write it only while the block
// is idle, which the block itself does not enforce. It takes effect on the next
// transfer; the history rings are cleared by reset.
// ----------------------------------------------------------------------------
module ultrasonic_echo_distance_qualifier_top #(
    parameter int unsigned HISTORY_DEPTH = 3
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [ued_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  ued_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output ued_pkg::out_item_t          m_data
);

    ued_pkg::cfg_t cfg_reg;
    logic          fe_valid;
    logic          fe_ready;
    ued_pkg::evt_t fe_data;
    logic          q_valid;
    logic          q_ready;
    ued_pkg::evt_t q_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.echo_offset    <= ued_pkg::RST_ECHO_OFFSET;
            cfg_reg.spread_limit   <= ued_pkg::RST_SPREAD_LIMIT;
            cfg_reg.unstable_value <= ued_pkg::RST_UNSTABLE_VALUE;
            cfg_reg.far_limit      <= ued_pkg::RST_FAR_LIMIT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ued_pkg::CFG_ECHO_OFFSET:    cfg_reg.echo_offset    <= cfg_data;
                ued_pkg::CFG_SPREAD_LIMIT:   cfg_reg.spread_limit   <= cfg_data[8:0];
                ued_pkg::CFG_UNSTABLE_VALUE: cfg_reg.unstable_value <= cfg_data[8:0];
                ued_pkg::CFG_FAR_LIMIT:      cfg_reg.far_limit      <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    ued_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .evt_valid (fe_valid),
        .evt_ready (fe_ready),
        .evt_data  (fe_data)
    );

    ued_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_data  (fe_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    ued_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .evt_valid (q_valid),
        .evt_ready (q_ready),
        .evt_data  (q_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the ultrasonic echo distance qualifier.
// ----------------------------------------------------------------------------
// Commands are driven on the s_ channel and results taken from the m_ channel,
// both with random idle bursts. A scoreboard object keeps its own copy of the
// sensor slot, the two history rings, the front latch and the registers, works
// out the result of every accepted command and compares each result field by
// field in order. A directed opening covers the slot rotation, zero, far and
// wrap-code distances; random phases under several register settings follow,
// one of them with a long output stall that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HIST_DEPTH  = 3;
    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned SETTLE      = 6;
    localparam int unsigned NUM_PHASES  = 8;
    localparam int unsigned PHASE_ITEMS = 200;
    localparam int unsigned QUIET_ITEMS = 100;
    localparam int unsigned SCALE_NUM   = 343;
    localparam int unsigned SCALE_DEN   = 10000;
    localparam int unsigned DW          = ued_pkg::DIST_W;
    localparam int unsigned CNT_W       = ued_pkg::COUNT_W;

    class echo_scoreboard;
        ued_pkg::cfg_t      cfg;
        logic [1:0]         slot;
        logic [DW-1:0]      left_hist [HIST_DEPTH];
        logic [DW-1:0]      right_hist[HIST_DEPTH];
        int unsigned        left_pos;
        int unsigned        right_pos;
        logic [DW-1:0]      front_last;
        ued_pkg::out_item_t expected_q[$];
        int unsigned        errors;

        function new();
            cfg.echo_offset    = ued_pkg::RST_ECHO_OFFSET;
            cfg.spread_limit   = ued_pkg::RST_SPREAD_LIMIT;
            cfg.unstable_value = ued_pkg::RST_UNSTABLE_VALUE;
            cfg.far_limit      = ued_pkg::RST_FAR_LIMIT;
            slot       = ued_pkg::SENSOR_RIGHT;
            left_pos   = 0;
            right_pos  = 0;
            front_last = '0;
            errors     = 0;
            foreach (left_hist[i]) begin
                left_hist[i]  = '0;
                right_hist[i] = '0;
            end
        endfunction

        function automatic logic [DW-1:0] to_distance(logic [CNT_W-1:0] count);
            logic [CNT_W-1:0] diff;
            int unsigned      q;
            int unsigned      raw;
            diff = count - cfg.echo_offset;
            q    = int'(diff >> 2);
            raw  = (q * SCALE_NUM) / SCALE_DEN;
            if (raw == int'(ued_pkg::WRAP_CODE)) return ued_pkg::WRAP_VALUE;
            if (raw >= int'(cfg.far_limit)) return DW'(cfg.unstable_value);
            return DW'(raw);
        endfunction

        function automatic logic [DW-1:0] qualified(logic [DW-1:0] hist[HIST_DEPTH]);
            logic [DW-1:0] lo;
            logic [DW-1:0] hi;
            lo = hist[0];
            hi = hist[0];
            for (int i = 1; i < HIST_DEPTH; i++) begin
                if (hist[i] > hi) hi = hist[i];
                if (hist[i] < lo) lo = hist[i];
            end
            return (hi - lo <= DW'(cfg.spread_limit)) ? lo : DW'(cfg.unstable_value);
        endfunction

        function void note_command(ued_pkg::in_item_t item);
            logic [DW-1:0]      echo_dist;
            ued_pkg::out_item_t want;
            echo_dist = '0;
            if (item.command == ued_pkg::CMD_SLOT_END) begin
                slot = (slot >= ued_pkg::SENSOR_FRONT) ? ued_pkg::SENSOR_RIGHT : slot + 2'd1;
            end else begin
                echo_dist = to_distance(item.echo_count);
                case (slot)
                    ued_pkg::SENSOR_RIGHT: begin
                        if (echo_dist != '0) begin
                            right_hist[right_pos] = echo_dist;
                            right_pos = (right_pos + 1) % HIST_DEPTH;
                        end
                    end
                    ued_pkg::SENSOR_LEFT: begin
                        if (echo_dist != '0) begin
                            left_hist[left_pos] = echo_dist;
                            left_pos = (left_pos + 1) % HIST_DEPTH;
                        end
                    end
                    ued_pkg::SENSOR_FRONT: begin
                        front_last = echo_dist;
                    end
                    default: ;
                endcase
            end
            want.active_sensor  = slot;
            want.echo_distance  = echo_dist;
            want.left_stable    = qualified(left_hist);
            want.right_stable   = qualified(right_hist);
            want.front_distance = front_last;
            expected_q.push_back(want);
        endfunction

        function void check_field(string name, logic [DW-1:0] want, logic [DW-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(ued_pkg::out_item_t got);
            ued_pkg::out_item_t want;
            if (expected_q.size() == 0) begin
                $error("result transfer with no command outstanding: %h", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            check_field("active_sensor", DW'(want.active_sensor), DW'(got.active_sensor));
            check_field("echo_distance", want.echo_distance, got.echo_distance);
            check_field("left_stable", want.left_stable, got.left_stable);
            check_field("right_stable", want.right_stable, got.right_stable);
            check_field("front_distance", want.front_distance, got.front_distance);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      cfg_we;
    logic [1:0]                cfg_index;
    logic [ued_pkg::CFG_W-1:0] cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    ued_pkg::in_item_t         s_data;
    logic                      m_valid;
    logic                      m_ready;
    ued_pkg::out_item_t        m_data;

    echo_scoreboard       sb;
    bit                   no_idle;
    bit                   hold_off_req;
    int unsigned          target_dist;

    ultrasonic_echo_distance_qualifier_top #(
        .HISTORY_DEPTH(HIST_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always #4 aclk = ~aclk;

    // Valid is left high after a transfer so that back-to-back commands never
    // see it lowered and raised in one step; idle bursts lower it.
    task automatic send_command(input ued_pkg::in_item_t item);
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_command(item);
    endtask

    function automatic ued_pkg::in_item_t make_item(logic cmd, logic [CNT_W-1:0] count);
        ued_pkg::in_item_t item;
        item.command    = cmd;
        item.echo_count = count;
        return item;
    endfunction

    // Echo count that converts to distance d under the current offset, for a jitter below 4.
    function automatic logic [CNT_W-1:0] count_for(int unsigned d, int unsigned jitter);
        int unsigned q;
        q = (d * SCALE_DEN + SCALE_NUM - 1) / SCALE_NUM;
        return sb.cfg.echo_offset + CNT_W'(4 * q + jitter);
    endfunction

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apply_config(input ued_pkg::cfg_t c);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= ued_pkg::CFG_ECHO_OFFSET;
        cfg_data  <= c.echo_offset;
        @(posedge aclk);
        cfg_index <= ued_pkg::CFG_SPREAD_LIMIT;
        cfg_data  <= ued_pkg::CFG_W'(c.spread_limit);
        @(posedge aclk);
        cfg_index <= ued_pkg::CFG_UNSTABLE_VALUE;
        cfg_data  <= ued_pkg::CFG_W'(c.unstable_value);
        @(posedge aclk);
        cfg_index <= ued_pkg::CFG_FAR_LIMIT;
        cfg_data  <= ued_pkg::CFG_W'(c.far_limit);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.cfg = c;
    endtask

    function automatic ued_pkg::cfg_t pick_config(int unsigned ph);
        ued_pkg::cfg_t c;
        c.echo_offset    = CNT_W'($urandom());
        c.spread_limit   = 9'($urandom_range(0, 511));
        c.unstable_value = 9'($urandom_range(0, 511));
        c.far_limit      = 10'($urandom_range(0, 1023));
        case (ph)
            0, 5: begin
                c.echo_offset    = ued_pkg::RST_ECHO_OFFSET;
                c.spread_limit   = ued_pkg::RST_SPREAD_LIMIT;
                c.unstable_value = ued_pkg::RST_UNSTABLE_VALUE;
                c.far_limit      = ued_pkg::RST_FAR_LIMIT;
            end
            1: c = '0;
            2: c = '{16'hFFFF, 9'd511, 9'd511, 10'd1023};
            3: begin
                c.spread_limit = 9'($urandom_range(0, 15));
                c.far_limit    = 10'd1023;
            end
            4: c.spread_limit = 9'($urandom_range(0, 8));
            6: begin
                c.spread_limit   = 9'd511;
                c.unstable_value = 9'd0;
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic run_directed();
        send_command(make_item(ued_pkg::CMD_SLOT_END, 16'hFFFF));
        send_command(make_item(ued_pkg::CMD_SLOT_END, 16'h0000));
        send_command(make_item(ued_pkg::CMD_SLOT_END, 16'hA5A5));
        // Right slot: a zero distance must not enter the ring.
        send_command(make_item(ued_pkg::CMD_ECHO, sb.cfg.echo_offset));
        send_command(make_item(ued_pkg::CMD_ECHO, count_for(100, 0)));
        send_command(make_item(ued_pkg::CMD_ECHO, count_for(101, 3)));
        send_command(make_item(ued_pkg::CMD_ECHO, count_for(102, 1)));
        send_command(make_item(ued_pkg::CMD_ECHO, count_for(103, 2)));
        send_command(make_item(ued_pkg::CMD_ECHO, count_for(520, 0)));
        send_command(make_item(ued_pkg::CMD_ECHO, count_for(561, 0)));
        send_command(make_item(ued_pkg::CMD_ECHO, sb.cfg.echo_offset - 16'd1));
        send_command(make_item(ued_pkg::CMD_ECHO, 16'h0000));
        send_command(make_item(ued_pkg::CMD_ECHO, 16'hFFFF));
        send_command(make_item(ued_pkg::CMD_SLOT_END, 16'h5A5A));
        send_command(make_item(ued_pkg::CMD_ECHO, sb.cfg.echo_offset));
        send_command(make_item(ued_pkg::CMD_ECHO, count_for(200, 0)));
        send_command(make_item(ued_pkg::CMD_ECHO, count_for(201, 0)));
        send_command(make_item(ued_pkg::CMD_ECHO, count_for(560, 0)));
        send_command(make_item(ued_pkg::CMD_SLOT_END, 16'h1234));
        // Front slot: a zero distance is still latched.
        send_command(make_item(ued_pkg::CMD_ECHO, sb.cfg.echo_offset));
        send_command(make_item(ued_pkg::CMD_ECHO, count_for(300, 0)));
        send_command(make_item(ued_pkg::CMD_ECHO, sb.cfg.echo_offset + 16'hFFFF));
        send_command(make_item(ued_pkg::CMD_SLOT_END, 16'hFFFF));
    endtask

    task automatic run_random(input int unsigned n);
        ued_pkg::in_item_t item;
        for (int unsigned k = 0; k < n; k++) begin
            if (!no_idle && $urandom_range(0, 4) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            if ($urandom_range(0, 19) == 0) target_dist = $urandom_range(1, 561);
            item.command = ($urandom_range(0, 99) < 30) ? ued_pkg::CMD_SLOT_END
                                                        : ued_pkg::CMD_ECHO;
            case ($urandom_range(0, 9))
                0: item.echo_count = CNT_W'($urandom());
                1: item.echo_count = sb.cfg.echo_offset;
                2: item.echo_count = sb.cfg.echo_offset + 16'd65424
                                     + 16'($urandom_range(0, 111));
                default: item.echo_count = count_for(target_dist, $urandom_range(0, 240));
            endcase
            send_command(item);
        end
    endtask

    // Output side: random stalls, one long hold on request, none at the end.
    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat (no_idle ? 1 : $urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    initial begin
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = ued_pkg::CFG_ECHO_OFFSET;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_data       = '0;
        no_idle      = 1'b0;
        hold_off_req = 1'b0;
        target_dist  = 100;
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
            apply_config(pick_config(ph));
            if (ph == 5) begin
                // Long output stall while commands keep coming, so the input backs up.
                hold_off_req = 1'b1;
                run_random(40);
                run_random(PHASE_ITEMS - 40);
            end else begin
                run_random(PHASE_ITEMS);
            end
        end
        no_idle = 1'b1;
        run_random(QUIET_ITEMS);

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
